[rtl/cbq_pkg.sv]
// shared constants, types and helpers for the circular byte queue
package cbq_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   localparam logic [1:0] FUNC_PUSH     = 2'd0;
   localparam logic [1:0] FUNC_POP      = 2'd1;
   localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       push_en;    // write word at tail+1, advance tail
      logic       pop_en;     // advance head
      logic       rd_en;      // read ring, load walk pointer with read address
      logic       rd_walk;    // read address from walk+1 instead of head+1
      logic       rsp_valid;
      logic [1:0] rsp_status;
      logic       rsp_last;
      logic       rsp_data_sel; // present read data instead of zero
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic full;
      logic head_next_last;
      logic walk_next_last;
   } stat_type;

   function automatic idx_type adv_idx(input idx_type idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

endpackage

[rtl/cbq_ctrl.sv]
// controller state machine for the circular byte queue
module cbq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_func,
   input  cbq_pkg::stat_type  stat,
   output logic               busy,
   output cbq_pkg::cmd_type   cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic state_ff;
   logic state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff == ST_WALK);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_func)
                  cbq_pkg::FUNC_PUSH: begin
                     cmd.rsp_valid = 1'b1;
                     cmd.rsp_last  = 1'b1;
                     if (stat.full) begin
                        cmd.rsp_status = cbq_pkg::STAT_FULL;
                     end else begin
                        cmd.push_en    = 1'b1;
                        cmd.rsp_status = cbq_pkg::STAT_OK;
                     end
                  end
                  cbq_pkg::FUNC_POP: begin
                     cmd.rsp_valid = 1'b1;
                     cmd.rsp_last  = 1'b1;
                     if (stat.empty) begin
                        cmd.rsp_status = cbq_pkg::STAT_EMPTY;
                     end else begin
                        cmd.rd_en        = 1'b1;
                        cmd.pop_en       = 1'b1;
                        cmd.rsp_data_sel = 1'b1;
                        cmd.rsp_status   = cbq_pkg::STAT_OK;
                     end
                  end
                  cbq_pkg::FUNC_TRAVERSE: begin
                     cmd.rsp_valid = 1'b1;
                     if (stat.empty) begin
                        cmd.rsp_status = cbq_pkg::STAT_EMPTY;
                        cmd.rsp_last   = 1'b1;
                     end else begin
                        cmd.rd_en        = 1'b1;
                        cmd.rsp_data_sel = 1'b1;
                        cmd.rsp_status   = cbq_pkg::STAT_OK;
                        cmd.rsp_last     = stat.head_next_last;
                        if (!stat.head_next_last) begin
                           state_in = ST_WALK;
                        end
                     end
                  end
                  default: begin
                     // unused code: no result
                  end
               endcase
            end
         end
         ST_WALK: begin
            cmd.rd_en        = 1'b1;
            cmd.rd_walk      = 1'b1;
            cmd.rsp_valid    = 1'b1;
            cmd.rsp_data_sel = 1'b1;
            cmd.rsp_status   = cbq_pkg::STAT_OK;
            cmd.rsp_last     = stat.walk_next_last;
            if (stat.walk_next_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/cbq_datapath.sv]
// ring memory, pointers and result registers for the circular byte queue
module cbq_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        req_push_value,
   input  cbq_pkg::cmd_type  cmd,
   output cbq_pkg::stat_type stat,
   output logic              rsp_valid,
   output logic [7:0]        rsp_data_out,
   output logic [1:0]        rsp_status,
   output logic              rsp_last
);

   logic [7:0] ring_mem [cbq_pkg::DEPTH];

   cbq_pkg::idx_type head_ff, tail_ff, walk_ff;
   cbq_pkg::idx_type head_nxt, tail_nxt, walk_nxt, rd_addr;

   logic [7:0] rd_data_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_last_ff;
   logic       data_sel_ff;

   always_comb begin
      head_nxt = cbq_pkg::adv_idx(head_ff);
      tail_nxt = cbq_pkg::adv_idx(tail_ff);
      walk_nxt = cbq_pkg::adv_idx(walk_ff);
      rd_addr  = cmd.rd_walk ? walk_nxt : head_nxt;

      stat.empty          = (head_ff == tail_ff);
      stat.full           = (tail_nxt == head_ff);
      stat.head_next_last = (head_nxt == tail_ff);
      stat.walk_next_last = (walk_nxt == tail_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.push_en) begin
            tail_ff <= tail_nxt;
         end
         if (cmd.pop_en) begin
            head_ff <= head_nxt;
         end
         if (cmd.rd_en) begin
            walk_ff <= rd_addr;
         end
         rsp_valid_ff <= cmd.rsp_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= cmd.rsp_status;
      rsp_last_ff   <= cmd.rsp_last;
      data_sel_ff   <= cmd.rsp_data_sel;
   end

   // ring storage
   always_ff @(posedge clock) begin
      if (cmd.push_en) begin
         ring_mem[tail_nxt] <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_data_out = data_sel_ff ? rd_data_ff : 8'd0;

endmodule

[rtl/circular_byte_queue_top.sv]
// top level of the circular byte queue
//
// circular byte queue over a ring of cbq_pkg::DEPTH slots, holding up to DEPTH-1 words.
// a command is taken at a rising edge with start high and busy low; req_func selects
// push (0), pop (1) or traverse (2), code 3 is ignored and gives no result.
// every result is registered and appears in the cycle after the edge that causes it, for exactly one cycle,
// flagged by rsp_valid; the receiver cannot stall, so results must be taken as they come.
// push and pop leave busy low, so a new command may follow at once.
// traverse emits one word per cycle, oldest first, one for each stored word (a single
// result when empty); the single read port of the ring sets this pace and
// busy stays high until the last word has been read.
// rsp_last marks the final result of each command; rsp_data_out is zero unless
// rsp_status is ok. status codes: 0 ok, 1 full on push, 2 empty.
module circular_byte_queue_top (
   input  logic       clock,
   input  logic       reset,
   // command side
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic [7:0] req_push_value,
   // result side
   output logic       rsp_valid,
   output logic [7:0] rsp_data_out,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   cbq_pkg::cmd_type  cmd;   // controller to datapath
   cbq_pkg::stat_type stat;  // pointer compares back to the controller

   // sequencing of push, pop and the traverse walk
   cbq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // ring, head/tail/walk pointers and result registers
   cbq_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_data_out   (rsp_data_out),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

[rtl/cbq_checker.sv]
// port-level checks for the circular byte queue, bound to the top level
module cbq_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [1:0] req_func,
   input logic       rsp_valid,
   input logic [7:0] rsp_data_out,
   input logic [1:0] rsp_status,
   input logic       rsp_last
);

   // push and pop answer with a single final word on the next cycle
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == cbq_pkg::FUNC_PUSH || req_func == cbq_pkg::FUNC_POP))
      |=> (rsp_valid && rsp_last))
      else $error("push or pop did not answer with one final word");

   // traverse always produces a first word on the next cycle
   a_trav_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == cbq_pkg::FUNC_TRAVERSE) |=> rsp_valid)
      else $error("traverse gave no word");

   // a word that is not the last one belongs to a walk still in progress
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final word without busy");

   // error status carries zero data and ends the command
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != cbq_pkg::STAT_OK) |-> (rsp_data_out == 8'd0 && rsp_last))
      else $error("error status with data or without last");

endmodule

bind circular_byte_queue_top cbq_checker u_cbq_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_func     (req_func),
   .rsp_valid    (rsp_valid),
   .rsp_data_out (rsp_data_out),
   .rsp_status   (rsp_status),
   .rsp_last     (rsp_last)
);
